>>> hw/rtl/tpe_pkg.sv
// Shared types, constants and modular helpers for the Tutte polynomial evaluator.
// No dependencies; used by the channel interfaces and tutte_polynomial_eval.
package tpe_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 10;
  localparam int unsigned VALUE_W = 30;

  typedef logic [VALUE_W-1:0] residue_t;

  localparam residue_t MODULUS = 30'd998244353;
  // floor(2^60 / p), Barrett constant for the 60-bit product reduction
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd998244353);

  // request opcodes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_EDGE  = 2'd1;
  localparam logic [1:0] MODE_EVAL  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_GEO_MUL,
    S_GEO_ADD,
    S_VTX,
    S_BLD_RD,
    S_BLD_MUL,
    S_BLD_WR,
    S_EX_START,
    S_EX_INIT_RD,
    S_EX_INIT_WR,
    S_EX_Z_RD,
    S_EX_Z_WR,
    S_EX_LD_RD,
    S_EX_LD_MUL,
    S_EX_LD_WR,
    S_EX_CV_MUL,
    S_EX_CV_ACC,
    S_EX_CV_INV,
    S_EX_CV_WR,
    S_EX_FIN_BASE,
    S_EX_FIN_RD,
    S_EX_FIN_WR,
    S_CC_SCAN,
    S_CC_GROW,
    S_SC_RD,
    S_SC_MUL,
    S_SC_WR,
    S_OUT_RD,
    S_OUT_WR,
    S_MUL_WAIT
  } tpe_state_t;

  function automatic residue_t add_mod(input residue_t a, input residue_t b);
    logic [VALUE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, MODULUS}) ? VALUE_W'(s - {1'b0, MODULUS}) : VALUE_W'(s);
  endfunction

  function automatic residue_t sub_mod(input residue_t a, input residue_t b);
    logic [VALUE_W:0] s;
    s = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
    return (a >= b) ? (a - b) : VALUE_W'(s);
  endfunction

  // Raw 30-bit field to a residue; a single subtract suffices below 2p
  function automatic residue_t reduce_mod(input residue_t v);
    return (v >= MODULUS) ? (v - MODULUS) : v;
  endfunction

  // Elaboration-time inverse by Fermat, for the constant inverse table
  function automatic residue_t mod_inverse(input int unsigned k);
    longint unsigned acc;
    longint unsigned bs;
    logic [VALUE_W-1:0] e;
    acc = 64'd1;
    bs  = 64'(k) % 64'd998244353;
    e   = MODULUS - 30'd2;
    for (int b = 0; b < VALUE_W; b++) begin
      if (e[b]) acc = (acc * bs) % 64'd998244353;
      bs = (bs * bs) % 64'd998244353;
    end
    return VALUE_W'(acc);
  endfunction

endpackage

>>> hw/rtl/tpe_req_if.sv
// Request channel of the Tutte polynomial evaluator: valid/ready plus item fields.
// Depends on tpe_pkg for the residue type.
interface tpe_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [3:0]        vertex_a;
  logic [3:0]        vertex_b;
  tpe_pkg::residue_t point_x;
  tpe_pkg::residue_t point_y;

  modport source (output valid, output mode, output vertex_a, output vertex_b,
                  output point_x, output point_y, input ready);
  modport sink   (input valid, input mode, input vertex_a, input vertex_b,
                  input point_x, input point_y, output ready);
endinterface

>>> hw/rtl/tpe_res_if.sv
// Result channel of the Tutte polynomial evaluator: valid/ready plus the value.
// Depends on tpe_pkg for the residue type.
interface tpe_res_if;
  logic              valid;
  logic              ready;
  tpe_pkg::residue_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> hw/rtl/tutte_polynomial_eval.sv
// Tutte polynomial T(x,y) mod 998244353 of a small graph, sequencer over two RAMs.
// Depends on tpe_pkg, tpe_req_if and tpe_res_if.
//
// Usage:
//   cfg_wr_en/cfg_wr_data set the vertex count (values above MAX_VERTICES act
//   as MAX_VERTICES); write it only while the block is idle.
//   req carries one request: clear the graph, add edge (vertex_a, vertex_b),
//   or evaluate at (point_x, point_y). Only an evaluation returns a result
//   on res.
//   Clear and add edge are applied as they are accepted. An evaluation walks the
//   subset tables held in two RAMs with registered reads, and every modular
//   product goes through one five-stage Barrett multiplier that is issued and
//   waited out per product, so only one product is in flight at a time.
//   The result sits in an output register; req.ready returns once the
//   evaluation is done, so a new request can be taken while res waits.
//   If res is still stalled when the next evaluation finishes, the block
//   holds that result until the register frees up.
//   Reset (rst, synchronous) clears the graph and the vertex count; the RAMs
//   need no clearing pass since every entry is written before it is read.
module tutte_polynomial_eval #(
  parameter int unsigned MAX_VERTICES = tpe_pkg::MAX_VERTICES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [3:0]    cfg_wr_data,
  tpe_req_if.sink       req,
  tpe_res_if.source     res
);
  import tpe_pkg::*;

  localparam int unsigned NV = MAX_VERTICES;
  localparam int unsigned CW = $clog2(NV + 1);
  localparam int unsigned SW = NV;
  localparam int unsigned RW = SW + CW;
  localparam int unsigned SV_DEPTH = 1 << SW;
  localparam int unsigned RK_DEPTH = 1 << RW;
  localparam logic [31:0] P32 = 32'(MODULUS);
  localparam logic [31:0] P2_32 = 32'(MODULUS) << 1;

  function automatic logic [CW-1:0] popc(input logic [SW-1:0] v);
    logic [CW-1:0] c;
    c = '0;
    for (int j = 0; j < SW; j++) c = c + CW'(v[j]);
    return c;
  endfunction

  // Control and counters
  tpe_state_t        state, state_next, ret_state, mul_ret;
  logic [3:0]        vertex_count;
  logic [CW-1:0]     n_eff;
  logic [CW-1:0]     u, m, k, l, i;
  logic [SW:0]       h, full, last_h, g;
  logic              hbit;
  logic [SW-1:0]     ebase;
  logic              final_exp, zsub;
  logic [SW:0]       mask_full;
  logic [SW-1:0]     mask_n;

  // Graph and component search
  logic [SW-1:0]     adj [NV];
  logic [SW-1:0]     adj_u, grow_or, grow_next;
  logic [SW-1:0]     visited, frontier, repr;

  // Small register files
  residue_t          geo [NV+1];
  residue_t          tmp [NV+1];
  residue_t          rowv [NV+1];
  residue_t          inv_rom [NV+1];
  residue_t          xr, yr, xm1, sum;

  // Output register
  logic              out_valid;
  residue_t          out_value;

  // Multiplier pipeline
  logic              mul_go;
  residue_t          mul_a, mul_b, mul_res;
  logic [4:0]        mul_vld;
  logic [59:0]       m1;
  logic [61:0]       m2;
  logic [31:0]       lo2, lo3, qp3, r4;
  residue_t          m5;

  // Memories
  residue_t          sv_mem [SV_DEPTH];
  residue_t          rk_mem [RK_DEPTH];
  logic              sv_re, sv_we;
  logic [SW-1:0]     sv_ra, sv_wa;
  residue_t          sv_wd, sv_rd;
  logic              rk_re, rk_we;
  logic [RW-1:0]     rk_ra_a, rk_ra_b, rk_wa;
  residue_t          rk_wd, rk_rda, rk_rdb;

  // Constant inverse table
  for (genvar gi = 0; gi <= NV; gi++) begin : g_inv
    assign inv_rom[gi] = (gi == 0) ? '0 : mod_inverse(gi);
  end

  // Derived loop bounds
  assign n_eff     = (32'(vertex_count) > NV) ? CW'(NV) : CW'(vertex_count);
  assign mask_full = (SW+1)'(1) << n_eff;
  assign mask_n    = SW'(mask_full - (SW+1)'(1));
  assign full      = (SW+1)'(1) << m;
  assign last_h    = full - (SW+1)'(1);
  assign g         = h | ((SW+1)'(1) << i);
  assign hbit      = |(h & ((SW+1)'(1) << i));

  // Row of the current vertex, and one frontier expansion
  always_comb begin
    adj_u   = '0;
    grow_or = '0;
    for (int r = 0; r < NV; r++) begin
      if (CW'(r) == u) adj_u = adj[r];
      if (frontier[r]) grow_or = grow_or | adj[r];
    end
    grow_next = grow_or & mask_n & ~(visited | frontier);
  end

  assign req.ready = (state == S_IDLE);
  assign res.valid = out_valid;
  assign res.value = out_value;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory / multiplier controls
  always_comb begin
    state_next = state;
    mul_ret    = ret_state;
    mul_go     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    sv_re      = 1'b0;
    sv_ra      = '0;
    sv_we      = 1'b0;
    sv_wa      = '0;
    sv_wd      = '0;
    rk_re      = 1'b0;
    rk_ra_a    = '0;
    rk_ra_b    = '0;
    rk_we      = 1'b0;
    rk_wa      = '0;
    rk_wd      = '0;
    unique case (state)
      S_IDLE: begin
        if (req.valid && req.mode == MODE_EVAL) begin
          sv_we      = 1'b1;
          state_next = (n_eff == '0) ? S_VTX : S_GEO_MUL;
        end
      end
      S_GEO_MUL: begin
        mul_go     = 1'b1;
        mul_a      = geo[u];
        mul_b      = yr;
        mul_ret    = S_GEO_ADD;
        state_next = S_MUL_WAIT;
      end
      S_GEO_ADD: begin
        state_next = (u + CW'(1) == n_eff) ? S_VTX : S_GEO_MUL;
      end
      S_VTX: begin
        state_next = (u == n_eff) ? S_CC_SCAN : S_BLD_RD;
      end
      S_BLD_RD: begin
        sv_re      = 1'b1;
        sv_ra      = h[SW-1:0];
        state_next = S_BLD_MUL;
      end
      S_BLD_MUL: begin
        mul_go     = 1'b1;
        mul_a      = sv_rd;
        mul_b      = geo[popc(h[SW-1:0] & adj_u)];
        mul_ret    = S_BLD_WR;
        state_next = S_MUL_WAIT;
      end
      S_BLD_WR: begin
        sv_we      = 1'b1;
        sv_wa      = ebase | h[SW-1:0];
        sv_wd      = mul_res;
        state_next = (h == {1'b0, ebase} - (SW+1)'(1)) ? S_EX_START : S_BLD_RD;
      end
      S_EX_START: begin
        state_next = (m == '0) ? S_EX_FIN_BASE : S_EX_INIT_RD;
      end
      S_EX_INIT_RD: begin
        sv_re      = 1'b1;
        sv_ra      = ebase | h[SW-1:0];
        state_next = S_EX_INIT_WR;
      end
      S_EX_INIT_WR: begin
        rk_we = 1'b1;
        rk_wa = {h[SW-1:0], k};
        rk_wd = (k == popc(h[SW-1:0])) ? sv_rd : '0;
        if (k == m) state_next = (h == last_h) ? S_EX_Z_RD : S_EX_INIT_RD;
      end
      S_EX_Z_RD: begin
        if (hbit) begin
          if (h == last_h && i == m - CW'(1))
            state_next = zsub ? S_EX_FIN_BASE : S_EX_LD_RD;
        end else begin
          rk_re      = 1'b1;
          rk_ra_a    = {g[SW-1:0], k};
          rk_ra_b    = {h[SW-1:0], k};
          state_next = S_EX_Z_WR;
        end
      end
      S_EX_Z_WR: begin
        rk_we      = 1'b1;
        rk_wa      = {g[SW-1:0], k};
        rk_wd      = zsub ? sub_mod(rk_rda, rk_rdb) : add_mod(rk_rda, rk_rdb);
        state_next = S_EX_Z_RD;
        if (k == m && h == last_h && i == m - CW'(1))
          state_next = zsub ? S_EX_FIN_BASE : S_EX_LD_RD;
      end
      S_EX_LD_RD: begin
        rk_re      = 1'b1;
        rk_ra_a    = {h[SW-1:0], k};
        state_next = S_EX_LD_MUL;
      end
      S_EX_LD_MUL: begin
        mul_go     = 1'b1;
        mul_a      = rk_rda;
        mul_b      = VALUE_W'(k);
        mul_ret    = S_EX_LD_WR;
        state_next = S_MUL_WAIT;
      end
      S_EX_LD_WR: begin
        state_next = (k == m) ? S_EX_CV_MUL : S_EX_LD_RD;
      end
      S_EX_CV_MUL: begin
        mul_go     = 1'b1;
        mul_a      = rowv[l];
        mul_b      = tmp[k - l];
        mul_ret    = S_EX_CV_ACC;
        state_next = S_MUL_WAIT;
      end
      S_EX_CV_ACC: begin
        state_next = (l == k) ? S_EX_CV_INV : S_EX_CV_MUL;
      end
      S_EX_CV_INV: begin
        mul_go     = 1'b1;
        mul_a      = inv_rom[k];
        mul_b      = sum;
        mul_ret    = S_EX_CV_WR;
        state_next = S_MUL_WAIT;
      end
      S_EX_CV_WR: begin
        rk_we = 1'b1;
        rk_wa = {h[SW-1:0], k};
        rk_wd = mul_res;
        if (k == m) state_next = (h == last_h) ? S_EX_Z_RD : S_EX_LD_RD;
        else        state_next = S_EX_CV_MUL;
      end
      S_EX_FIN_BASE: begin
        sv_we = 1'b1;
        sv_wa = ebase;
        sv_wd = VALUE_W'(1);
        if (m == '0) state_next = final_exp ? S_OUT_RD : S_VTX;
        else         state_next = S_EX_FIN_RD;
      end
      S_EX_FIN_RD: begin
        rk_re      = 1'b1;
        rk_ra_a    = {h[SW-1:0], popc(h[SW-1:0])};
        state_next = S_EX_FIN_WR;
      end
      S_EX_FIN_WR: begin
        sv_we = 1'b1;
        sv_wa = ebase | h[SW-1:0];
        sv_wd = rk_rda;
        if (h == last_h) state_next = final_exp ? S_OUT_RD : S_VTX;
        else             state_next = S_EX_FIN_RD;
      end
      S_CC_SCAN: begin
        if (u == n_eff) state_next = S_SC_RD;
        else if (((visited >> u) & SW'(1)) == '0) state_next = S_CC_GROW;
      end
      S_CC_GROW: begin
        if (grow_next == '0) state_next = S_CC_SCAN;
      end
      S_SC_RD: begin
        if ((h[SW-1:0] & repr) != '0) begin
          if (h[SW-1:0] == mask_n) state_next = S_EX_START;
        end else begin
          sv_re      = 1'b1;
          sv_ra      = h[SW-1:0];
          state_next = S_SC_MUL;
        end
      end
      S_SC_MUL: begin
        mul_go     = 1'b1;
        mul_a      = sv_rd;
        mul_b      = xm1;
        mul_ret    = S_SC_WR;
        state_next = S_MUL_WAIT;
      end
      S_SC_WR: begin
        sv_we      = 1'b1;
        sv_wa      = h[SW-1:0];
        sv_wd      = mul_res;
        state_next = (h[SW-1:0] == mask_n) ? S_EX_START : S_SC_RD;
      end
      S_OUT_RD: begin
        sv_re      = 1'b1;
        sv_ra      = mask_n;
        state_next = S_OUT_WR;
      end
      S_OUT_WR: begin
        if (!out_valid || res.ready) state_next = S_IDLE;
      end
      S_MUL_WAIT: begin
        if (mul_vld[4]) state_next = ret_state;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Graph store: clear and add-edge requests
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NV; r++) adj[r] <= '0;
    end else if (req.valid && req.ready) begin
      if (req.mode == MODE_CLEAR) begin
        for (int r = 0; r < NV; r++) adj[r] <= '0;
      end else if (req.mode == MODE_EDGE && 32'(req.vertex_a) < 32'(n_eff) &&
                   32'(req.vertex_b) < 32'(n_eff) && req.vertex_a != req.vertex_b) begin
        for (int r = 0; r < NV; r++) begin
          for (int c = 0; c < NV; c++) begin
            if ((32'(req.vertex_a) == r && 32'(req.vertex_b) == c) ||
                (32'(req.vertex_b) == r && 32'(req.vertex_a) == c))
              adj[r][c] <= 1'b1;
          end
        end
      end
    end
  end

  // Sequencer datapath: counters, small register files, search masks
  always_ff @(posedge clk) begin
    if (mul_go) ret_state <= mul_ret;
    if (state == S_MUL_WAIT && mul_vld[4]) mul_res <= m5;
    unique case (state)
      S_IDLE: begin
        if (req.valid && req.mode == MODE_EVAL) begin
          xr        <= reduce_mod(req.point_x);
          yr        <= reduce_mod(req.point_y);
          u         <= '0;
          geo[0]    <= '0;
          final_exp <= 1'b0;
        end
      end
      S_GEO_ADD: begin
        geo[u + CW'(1)] <= add_mod(mul_res, VALUE_W'(1));
        u <= (u + CW'(1) == n_eff) ? '0 : u + CW'(1);
      end
      S_VTX: begin
        visited  <= '0;
        repr     <= '0;
        ebase    <= SW'(1) << u;
        h        <= '0;
        if (u == n_eff) u <= '0;
      end
      S_BLD_WR: begin
        h <= h + (SW+1)'(1);
        m <= u;
      end
      S_EX_START: begin
        h      <= (SW+1)'(1);
        k      <= CW'(1);
        tmp[0] <= VALUE_W'(1);
      end
      S_EX_INIT_WR: begin
        if (k == m) begin
          k <= CW'(1);
          if (h == last_h) begin
            h    <= (SW+1)'(1);
            i    <= '0;
            zsub <= 1'b0;
          end else begin
            h <= h + (SW+1)'(1);
          end
        end else begin
          k <= k + CW'(1);
        end
      end
      S_EX_Z_RD, S_EX_Z_WR: begin
        if (state == S_EX_Z_WR && k != m) begin
          k <= k + CW'(1);
        end else if (state == S_EX_Z_WR || hbit) begin
          k <= CW'(1);
          if (h == last_h) begin
            h <= (SW+1)'(1);
            i <= (i == m - CW'(1)) ? '0 : i + CW'(1);
          end else begin
            h <= h + (SW+1)'(1);
          end
        end
      end
      S_EX_LD_WR: begin
        rowv[k] <= mul_res;
        if (k == m) begin
          k   <= CW'(1);
          l   <= CW'(1);
          sum <= '0;
        end else begin
          k <= k + CW'(1);
        end
      end
      S_EX_CV_ACC: begin
        sum <= add_mod(sum, mul_res);
        if (l != k) l <= l + CW'(1);
      end
      S_EX_CV_WR: begin
        tmp[k] <= mul_res;
        l      <= CW'(1);
        sum    <= '0;
        if (k == m) begin
          k <= CW'(1);
          if (h == last_h) begin
            h    <= (SW+1)'(1);
            i    <= '0;
            zsub <= 1'b1;
          end else begin
            h <= h + (SW+1)'(1);
          end
        end else begin
          k <= k + CW'(1);
        end
      end
      S_EX_FIN_BASE: begin
        h <= (SW+1)'(1);
        if (m == '0 && !final_exp) u <= u + CW'(1);
      end
      S_EX_FIN_WR: begin
        h <= h + (SW+1)'(1);
        if (h == last_h && !final_exp) u <= u + CW'(1);
      end
      S_CC_SCAN: begin
        if (u == n_eff) begin
          h   <= '0;
          xm1 <= sub_mod(xr, VALUE_W'(1));
        end else if (((visited >> u) & SW'(1)) != '0) begin
          u <= u + CW'(1);
        end else begin
          frontier <= SW'(1) << u;
          repr     <= repr | (SW'(1) << u);
        end
      end
      S_CC_GROW: begin
        visited  <= visited | frontier;
        frontier <= grow_next;
        if (grow_next == '0) u <= u + CW'(1);
      end
      S_SC_RD, S_SC_WR: begin
        if (state == S_SC_WR || (h[SW-1:0] & repr) != '0) begin
          if (h[SW-1:0] == mask_n) begin
            m         <= n_eff;
            ebase     <= '0;
            final_exp <= 1'b1;
          end else begin
            h <= h + (SW+1)'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT_WR && (!out_valid || res.ready)) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT_WR && (!out_valid || res.ready)) out_value <= sv_rd;
  end

  // Barrett modular multiplier, five stages
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= '0;
    end else begin
      mul_vld <= {mul_vld[3:0], mul_go};
    end
  end

  always_ff @(posedge clk) begin
    m1  <= 60'(mul_a) * 60'(mul_b);
    m2  <= 62'(m1[59:29]) * 62'(BARRETT_MU);
    lo2 <= m1[31:0];
    qp3 <= 32'(m2[61:31]) * P32;
    lo3 <= lo2;
    r4  <= lo3 - qp3;
    if (r4 >= P2_32)    m5 <= VALUE_W'(r4 - P2_32);
    else if (r4 >= P32) m5 <= VALUE_W'(r4 - P32);
    else                m5 <= VALUE_W'(r4);
  end

  // Subset value RAM
  always_ff @(posedge clk) begin
    if (sv_we) sv_mem[sv_wa] <= sv_wd;
    if (sv_re) sv_rd <= sv_mem[sv_ra];
  end

  // Ranked table RAM, two read ports
  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[rk_wa] <= rk_wd;
    if (rk_re) begin
      rk_rda <= rk_mem[rk_ra_a];
      rk_rdb <= rk_mem[rk_ra_b];
    end
  end

`ifndef NO_ASSERTIONS
  // Only one product in flight at a time
  a_mul_single: assert property (@(posedge clk) disable iff (rst)
    $countones(mul_vld) <= 1)
    else $error("more than one product in the multiplier");

  // Waiting on the multiplier implies a product is actually in flight
  a_wait_has_mul: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL_WAIT |-> mul_vld != '0)
    else $error("multiplier wait with nothing issued");

  // A finished result is never dropped over a pending one
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT_WR && out_valid && !res.ready) |=> state == S_OUT_WR)
    else $error("result left while output register full");

  // An accepted evaluation leaves idle
  a_eval_start: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.mode == MODE_EVAL) |=> state != S_IDLE)
    else $error("evaluation request not started");
`endif

endmodule
